// ===== design/fmd_pkg.sv =====
`default_nettype none

package fmd_pkg;

    // Field widths of the request and result items
    localparam int FUNC_W    = 2;
    localparam int TREE_ID_W = 7;
    localparam int POINT_W   = 12;
    localparam int NODE_W    = 9;
    localparam int MASS_W    = 13;
    localparam int MSUM_W    = 20;
    localparam int SCORE_W   = 16;

    // Configuration register widths
    localparam int TCNT_W = 8;
    localparam int PCNT_W = 13;
    localparam int MU_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Internal datapath widths
    localparam int SUM_W  = MASS_W + TCNT_W;
    localparam int DEN_W  = TCNT_W + PCNT_W;
    localparam int ALU_W  = DEN_W + 1;
    localparam int STEP_W = 4;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_LEAF  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MASS  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [TREE_ID_W-1:0] tree_id;
        logic [POINT_W-1:0]   point_a;
        logic [POINT_W-1:0]   point_b;
        logic [NODE_W-1:0]    node_id;
        logic [MASS_W-1:0]    mass_value;
    } in_item_t;

    typedef struct packed {
        logic [MSUM_W-1:0]  mass_sum;
        logic [SCORE_W-1:0] score;
        logic               below_threshold;
    } out_item_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic carry;
        logic zero;
    } alu_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP_A,
        ST_WRAP_B,
        ST_LEAF_A,
        ST_LEAF_B,
        ST_LOAD,
        ST_CLIMB,
        ST_ACC,
        ST_DIV_CHK,
        ST_DIV,
        ST_MU_CMP,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== design/fmd_ram.sv =====
`default_nettype none

module fmd_ram #(
    parameter int WIDTH  = 9,
    parameter int ADDR_W = 19
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    // Write on request, read with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/fmd_alu.sv =====
`default_nettype none

module fmd_alu (
    input  wire fmd_pkg::alu_op_t              op,
    input  wire logic [fmd_pkg::ALU_W-1:0]     a,
    input  wire logic [fmd_pkg::ALU_W-1:0]     b,
    output logic      [fmd_pkg::ALU_W-1:0]     result,
    output fmd_pkg::alu_flags_t                flags
);

    import fmd_pkg::*;

    logic [ALU_W:0] full;

    // Add, or subtract with carry meaning a >= b
    always_comb
    begin
        unique case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} + {1'b0, ~b} + (ALU_W + 1)'(1);
        endcase
    end

    assign result      = full[ALU_W-1:0];
    assign flags.carry = full[ALU_W];
    assign flags.zero  = (full[ALU_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== design/forest_mass_dissimilarity.sv =====
`default_nettype none

// Mass-based dissimilarity over a forest of heap-indexed binary trees.
// Requests come in on in_valid/in_ready/in_data. A leaf load (func 0) or a
// mass load (func 1) writes one table entry; a query (func 2) names two
// points. Each request gives exactly one result on out_valid/out_ready/
// out_data; loads and the unused code give an all-zero result.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high. Write them only while no request is in flight.
// A load goes straight to the finish state. A query first wraps the two
// points by repeated subtraction; then, per tree, it reads both leaves
// through the table's single read port, climbs one step a cycle on the
// shared adder to the common ancestor and adds that node's mass. A restoring
// divide, skipped when the score saturates, and a threshold compare end it.
// in_ready is high only while the sequencer is idle. A finished result waits
// in the output register while the receiver stalls, and the next request is
// taken meanwhile. Reset clears the sequencer, the output valid and the
// configuration (128 trees, 4096 points, threshold 0); the tables are not
// cleared and must be loaded before a query reads them.

module forest_mass_dissimilarity #(
    parameter int MAX_TREES  = 128,
    parameter int MAX_POINTS = 4096,
    parameter int MAX_NODES  = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire fmd_pkg::in_item_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output fmd_pkg::out_item_t                     out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fmd_pkg::*;

    localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_NODES);
    localparam int LEAF_AW = TW + PW;
    localparam int MASS_AW = TW + NW;
    localparam logic [TCNT_W-1:0] TREE_CAP =
        TCNT_W'((MAX_TREES > (2**TCNT_W - 1)) ? (2**TCNT_W - 1) : MAX_TREES);
    localparam logic [POINT_W:0] WRAP_OFF = (POINT_W + 1)'(2**POINT_W);

    // Multiple of the point range used at one step of the wrap
    function automatic logic [POINT_W:0] wrap_div(input logic [STEP_W-1:0] k);
        longint d;
        d = longint'(MAX_POINTS) << k;
        return (d >= longint'(2**POINT_W)) ? WRAP_OFF : (POINT_W + 1)'(d);
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [TCNT_W-1:0] tree_count_reg;
    logic [PCNT_W-1:0] point_count_reg;
    logic [MU_W-1:0]   mu_threshold_reg;

    logic [POINT_W-1:0] pa_reg;
    logic [POINT_W-1:0] pb_reg;
    logic [NODE_W-1:0]  x_reg;
    logic [NODE_W-1:0]  y_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DEN_W-1:0]   denom_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [SCORE_W-1:0] q_reg;
    logic               below_reg;
    logic [TCNT_W-1:0]  t_reg;
    logic [TCNT_W-1:0]  last_reg;
    logic [STEP_W-1:0]  step_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic [TCNT_W-1:0] trees_eff;
    logic [PCNT_W-1:0] points_eff;
    logic              accept;
    logic              out_free;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [ALU_W-1:0] alu_result;
    alu_flags_t       alu_flags;

    logic               leaf_wr_en;
    logic               mass_wr_en;
    logic [LEAF_AW-1:0] leaf_rd_addr;
    logic [NODE_W-1:0]  leaf_rd_data;
    logic [MASS_W-1:0]  mass_rd_data;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the configured counts
    always_comb
    begin
        priority if (tree_count_reg == '0)
        begin
            trees_eff = TCNT_W'(1);
        end
        else if (tree_count_reg > TREE_CAP)
        begin
            trees_eff = TREE_CAP;
        end
        else
        begin
            trees_eff = tree_count_reg;
        end
        points_eff = (point_count_reg == '0) ? PCNT_W'(1) : point_count_reg;
    end

    // Decode table writes from accepted load requests
    assign leaf_wr_en = accept && (in_data.func == FUNC_LEAF)
                        && (32'(in_data.tree_id) < MAX_TREES)
                        && (32'(in_data.point_a) < MAX_POINTS)
                        && (32'(in_data.node_id) < MAX_NODES);
    assign mass_wr_en = accept && (in_data.func == FUNC_MASS)
                        && (32'(in_data.tree_id) < MAX_TREES)
                        && (32'(in_data.node_id) < MAX_NODES);

    fmd_ram #(
        .WIDTH  (NODE_W),
        .ADDR_W (LEAF_AW)
    ) u_leaf_table (
        .clk     (clk),
        .wr_en   (leaf_wr_en),
        .wr_addr ({TW'(in_data.tree_id), PW'(in_data.point_a)}),
        .wr_data (in_data.node_id),
        .rd_addr (leaf_rd_addr),
        .rd_data (leaf_rd_data)
    );

    fmd_ram #(
        .WIDTH  (MASS_W),
        .ADDR_W (MASS_AW)
    ) u_mass_table (
        .clk     (clk),
        .wr_en   (mass_wr_en),
        .wr_addr ({TW'(in_data.tree_id), NW'(in_data.node_id)}),
        .wr_data (in_data.mass_value),
        .rd_addr ({TW'(t_reg), NW'(x_reg)}),
        .rd_data (mass_rd_data)
    );

    fmd_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .flags  (alu_flags)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg   <= TCNT_W'(128);
            point_count_reg  <= PCNT_W'(4096);
            mu_threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TREE_COUNT:   tree_count_reg   <= cfg_data[TCNT_W-1:0];
                CFG_POINT_COUNT:  point_count_reg  <= cfg_data[PCNT_W-1:0];
                CFG_MU_THRESHOLD: mu_threshold_reg <= cfg_data[MU_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.func == FUNC_QUERY) ? ST_WRAP_A : ST_FINISH;
                end
            end
            ST_WRAP_A:  if (step_reg == '0) state_next = ST_WRAP_B;
            ST_WRAP_B:  if (step_reg == '0) state_next = ST_LEAF_A;
            ST_LEAF_A:  state_next = ST_LEAF_B;
            ST_LEAF_B:  state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_CLIMB;
            ST_CLIMB:   if (alu_flags.zero) state_next = ST_ACC;
            ST_ACC:     state_next = (t_reg == last_reg) ? ST_DIV_CHK : ST_LEAF_A;
            ST_DIV_CHK: state_next = alu_flags.carry ? ST_MU_CMP : ST_DIV;
            ST_DIV:     if (step_reg == '0) state_next = ST_MU_CMP;
            ST_MU_CMP:  state_next = ST_FINISH;
            ST_FINISH:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, shared unit operands, leaf read address
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        alu_op       = ALU_SUB;
        alu_a        = '0;
        alu_b        = '0;
        leaf_rd_addr = {TW'(t_reg), PW'(pa_reg)};
        unique case (state_reg)
            ST_WRAP_A:
            begin
                alu_a = ALU_W'(pa_reg);
                alu_b = ALU_W'(wrap_div(step_reg));
            end
            ST_WRAP_B:
            begin
                alu_a = ALU_W'(pb_reg);
                alu_b = ALU_W'(wrap_div(step_reg));
            end
            ST_LEAF_B:
            begin
                leaf_rd_addr = {TW'(t_reg), PW'(pb_reg)};
            end
            ST_CLIMB:
            begin
                alu_a = ALU_W'(x_reg);
                alu_b = ALU_W'(y_reg);
            end
            ST_ACC:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(sum_reg);
                alu_b  = ALU_W'(mass_rd_data);
            end
            ST_DIV_CHK:
            begin
                alu_a = ALU_W'(sum_reg);
                alu_b = ALU_W'(denom_reg);
            end
            ST_DIV:
            begin
                alu_a = {rem_reg, 1'b0};
                alu_b = ALU_W'(denom_reg);
            end
            ST_MU_CMP:
            begin
                alu_a = ALU_W'(q_reg);
                alu_b = ALU_W'(mu_threshold_reg);
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // Query datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pa_reg    <= in_data.point_a;
                    pb_reg    <= in_data.point_b;
                    sum_reg   <= '0;
                    q_reg     <= '0;
                    below_reg <= 1'b0;
                    t_reg     <= '0;
                    last_reg  <= trees_eff - TCNT_W'(1);
                    denom_reg <= DEN_W'(trees_eff) * DEN_W'(points_eff);
                    step_reg  <= STEP_W'(POINT_W - 1);
                end
            end
            ST_WRAP_A:
            begin
                if (alu_flags.carry)
                begin
                    pa_reg <= alu_result[POINT_W-1:0];
                end
                step_reg <= (step_reg == '0) ? STEP_W'(POINT_W - 1) : step_reg - 1'b1;
            end
            ST_WRAP_B:
            begin
                if (alu_flags.carry)
                begin
                    pb_reg <= alu_result[POINT_W-1:0];
                end
                step_reg <= step_reg - 1'b1;
            end
            ST_LEAF_B:
            begin
                x_reg <= leaf_rd_data;
            end
            ST_LOAD:
            begin
                y_reg <= leaf_rd_data;
            end
            ST_CLIMB:
            begin
                // Step the larger index to its parent
                if (!alu_flags.zero)
                begin
                    if (alu_flags.carry)
                    begin
                        x_reg <= (x_reg - 1'b1) >> 1;
                    end
                    else
                    begin
                        y_reg <= (y_reg - 1'b1) >> 1;
                    end
                end
            end
            ST_ACC:
            begin
                sum_reg <= alu_result[SUM_W-1:0];
                t_reg   <= t_reg + 1'b1;
            end
            ST_DIV_CHK:
            begin
                // Saturate when the quotient cannot fit
                if (alu_flags.carry)
                begin
                    q_reg <= '1;
                end
                else
                begin
                    rem_reg  <= DEN_W'(sum_reg);
                    step_reg <= STEP_W'(SCORE_W - 1);
                end
            end
            ST_DIV:
            begin
                if (alu_flags.carry)
                begin
                    rem_reg <= alu_result[DEN_W-1:0];
                    q_reg   <= {q_reg[SCORE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DEN_W-2:0], 1'b0};
                    q_reg   <= {q_reg[SCORE_W-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
            end
            ST_MU_CMP:
            begin
                below_reg <= !alu_flags.carry;
            end
            default:
            begin
                below_reg <= below_reg;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg.mass_sum        <= sum_reg[MSUM_W-1:0];
            out_data_reg.score           <= q_reg;
            out_data_reg.below_threshold <= below_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sim/dissimilarity_checker.sv =====
`timescale 1ns / 1ps

module dissimilarity_checker
    import fmd_pkg::*;
#(
    parameter int N_TREES  = 128,
    parameter int N_POINTS = 4096,
    parameter int N_NODES  = 512
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_ready,
    input  wire in_item_t                in_data,
    input  wire logic                    out_valid,
    input  wire logic                    out_ready,
    input  wire out_item_t               out_data,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    output int                           scores_due,
    output int                           mismatch_count
);

    // Shadow copies of the leaf and mass tables, keyed by tree and point/node
    logic [NODE_W-1:0] leaf_mem [int];
    logic [MASS_W-1:0] mass_mem [int];

    // Shadow configuration
    logic [TCNT_W-1:0] trees_reg;
    logic [PCNT_W-1:0] points_reg;
    logic [MU_W-1:0]   mu_reg;

    // Results owed by the block, oldest first
    out_item_t score_queue [$];
    out_item_t want;

    // Climb the larger heap index until both meet
    function automatic int shared_ancestor(input int x, input int y);
        while (x != y) begin
            if (x > y)
                x = (x - 1) / 2;
            else
                y = (y - 1) / 2;
        end
        return x;
    endfunction

    // Sum ancestor masses over the configured trees and scale to Q0.16
    function automatic out_item_t score_pair(input in_item_t req);
        int        trees;
        int        points;
        int        la;
        int        lb;
        int        anc;
        longint    sum;
        longint    frac;
        out_item_t res;
        res = '0;
        trees = (trees_reg == 0) ? 1 : int'(trees_reg);
        if (trees > N_TREES)
            trees = N_TREES;
        points = (points_reg == 0) ? 1 : int'(points_reg);
        sum = 0;
        for (int t = 0; t < trees; t++) begin
            la = 0;
            lb = 0;
            if (leaf_mem.exists(t * N_POINTS + int'(req.point_a) % N_POINTS))
                la = leaf_mem[t * N_POINTS + int'(req.point_a) % N_POINTS];
            if (leaf_mem.exists(t * N_POINTS + int'(req.point_b) % N_POINTS))
                lb = leaf_mem[t * N_POINTS + int'(req.point_b) % N_POINTS];
            anc = shared_ancestor(la, lb);
            if (anc < N_NODES && mass_mem.exists(t * N_NODES + anc))
                sum += mass_mem[t * N_NODES + anc];
        end
        frac = (sum << 16) / (longint'(trees) * points);
        if (frac > 65535)
            frac = 65535;
        res.mass_sum        = sum[MSUM_W-1:0];
        res.score           = frac[SCORE_W-1:0];
        res.below_threshold = (frac < longint'(mu_reg));
        return res;
    endfunction

    // Apply one request to the shadow state and return the owed result
    function automatic out_item_t apply_request(input in_item_t req);
        out_item_t res;
        res = '0;
        case (req.func)
            FUNC_LEAF:
                if (req.tree_id < N_TREES && req.point_a < N_POINTS && req.node_id < N_NODES)
                    leaf_mem[int'(req.tree_id) * N_POINTS + int'(req.point_a)] = req.node_id;
            FUNC_MASS:
                if (req.tree_id < N_TREES && req.node_id < N_NODES)
                    mass_mem[int'(req.tree_id) * N_NODES + int'(req.node_id)] = req.mass_value;
            FUNC_QUERY:
                res = score_pair(req);
            default: ;
        endcase
        return res;
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report(input string what, input longint got, input longint exp_val);
        if (mismatch_count < 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Track config writes, queue predictions, compare results
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            trees_reg      = 8'd128;
            points_reg     = 13'd4096;
            mu_reg         = '0;
            score_queue.delete();
            scores_due     = 0;
            mismatch_count = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (score_queue.size() == 0) begin
                    report("result with no request outstanding, mass_sum",
                           out_data.mass_sum, 0);
                end else begin
                    want = score_queue.pop_front();
                    if (out_data.mass_sum !== want.mass_sum)
                        report("mass_sum", out_data.mass_sum, want.mass_sum);
                    if (out_data.score !== want.score)
                        report("score", out_data.score, want.score);
                    if (out_data.below_threshold !== want.below_threshold)
                        report("below_threshold", out_data.below_threshold,
                               want.below_threshold);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TREE_COUNT:   trees_reg  = cfg_data[TCNT_W-1:0];
                    CFG_POINT_COUNT:  points_reg = cfg_data[PCNT_W-1:0];
                    CFG_MU_THRESHOLD: mu_reg     = cfg_data[MU_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                score_queue.push_back(apply_request(in_data));
            scores_due = score_queue.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fmd_pkg::*;

    localparam int N_TREES  = 128;
    localparam int N_POINTS = 4096;
    localparam int N_NODES  = 512;

    // Unused function code: the block writes no table and gives an all-zero result
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    scores_due;
    int                    mismatch_count;

    // Stimulus bookkeeping: known leaves and loaded masses
    logic [NODE_W-1:0] leaf_at [int];
    bit                mass_set [int];
    int                trees_now = N_TREES;
    int                burst_left = 0;
    int                sent_count = 0;
    bit                heavy_masses = 1'b0;
    int                point_pool [16];
    int                rx_tick = 0;
    int                stall_left = 0;

    forest_mass_dissimilarity #(
        .MAX_TREES  (N_TREES),
        .MAX_POINTS (N_POINTS),
        .MAX_NODES  (N_NODES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dissimilarity_checker #(
        .N_TREES  (N_TREES),
        .N_POINTS (N_POINTS),
        .N_NODES  (N_NODES)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .scores_due     (scores_due),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: cycle through always-ready, light and heavy random stalls, long stalls
    always @(negedge clk)
    begin
        rx_tick++;
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready = 1'b0;
        end
        else
        begin
            case ((rx_tick / 97) % 4)
                0: out_ready = 1'b1;
                1: out_ready = ($urandom_range(0, 3) != 0);
                2: out_ready = $urandom_range(0, 1);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(4, 24);
                        out_ready  = 1'b0;
                    end
                    else
                        out_ready = 1'b1;
                end
            endcase
        end
    end

    // Stimulus-side copy of the climb, used to pick which masses to load
    function automatic int meet_node(input int x, input int y);
        while (x != y)
        begin
            if (x > y)
                x = (x - 1) / 2;
            else
                y = (y - 1) / 2;
        end
        return x;
    endfunction

    function automatic int random_node();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return N_NODES - 1;
            2, 3, 4, 5, 6, 7: return $urandom_range(N_NODES / 2 - 1, N_NODES - 1);
            default: return $urandom_range(0, N_NODES - 1);
        endcase
    endfunction

    function automatic int random_mass();
        if (heavy_masses)
            return $urandom_range(8000, 8191);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 8191;
            2:       return 4096;
            3:       return $urandom_range(0, 8191);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // Many trees: stay on the two points loaded everywhere; else the pool or any point
    function automatic int pick_point();
        if (trees_now > 8)
            return point_pool[$urandom_range(0, 1)];
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, N_POINTS - 1);
        return point_pool[$urandom_range(0, 15)];
    endfunction

    // Present one request; bursts of random length separated by random gaps
    task automatic send_request(input in_item_t req);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        in_data  = req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent_count++;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_idle(input int tail);
        in_valid = 1'b0;
        while (scores_due != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_TREE_COUNT)
        begin
            trees_now = (val[TCNT_W-1:0] == 0) ? 1 : int'(val[TCNT_W-1:0]);
            if (trees_now > N_TREES)
                trees_now = N_TREES;
        end
    endtask

    task automatic load_leaf(input int tree, input int pt, input int node);
        in_item_t req;
        req            = '0;
        req.func       = FUNC_LEAF;
        req.tree_id    = TREE_ID_W'(tree);
        req.point_a    = POINT_W'(pt);
        req.point_b    = POINT_W'($urandom);
        req.node_id    = NODE_W'(node);
        req.mass_value = MASS_W'($urandom);
        leaf_at[tree * N_POINTS + pt] = NODE_W'(node);
        send_request(req);
    endtask

    task automatic load_mass(input int tree, input int node, input int mass);
        in_item_t req;
        req            = '0;
        req.func       = FUNC_MASS;
        req.tree_id    = TREE_ID_W'(tree);
        req.point_a    = POINT_W'($urandom);
        req.point_b    = POINT_W'($urandom);
        req.node_id    = NODE_W'(node);
        req.mass_value = MASS_W'(mass);
        mass_set[tree * N_NODES + node] = 1'b1;
        send_request(req);
    endtask

    // Load whatever the pair still lacks in the summed trees, then query
    task automatic query_pair(input int pa, input int pb);
        int       anc;
        in_item_t req;
        for (int t = 0; t < trees_now; t++)
        begin
            if (!leaf_at.exists(t * N_POINTS + pa))
                load_leaf(t, pa, random_node());
            if (!leaf_at.exists(t * N_POINTS + pb))
                load_leaf(t, pb, random_node());
            anc = meet_node(leaf_at[t * N_POINTS + pa], leaf_at[t * N_POINTS + pb]);
            if (!mass_set.exists(t * N_NODES + anc))
                load_mass(t, anc, random_mass());
        end
        req            = '0;
        req.func       = FUNC_QUERY;
        req.tree_id    = TREE_ID_W'($urandom);
        req.point_a    = POINT_W'(pa);
        req.point_b    = POINT_W'(pb);
        req.node_id    = NODE_W'($urandom);
        req.mass_value = MASS_W'($urandom);
        send_request(req);
    endtask

    task automatic spare_request(input bit all_ones);
        in_item_t req;
        req      = all_ones ? '1 : in_item_t'($urandom);
        req.func = FUNC_SPARE;
        send_request(req);
    endtask

    // Hard stop
    initial
    begin
        #20_000_000;
        $display("forest_mass_dissimilarity test failed");
        $finish;
    end

    initial
    begin
        int stop_at;
        int pick;
        point_pool[0] = 0;
        point_pool[1] = N_POINTS - 1;
        for (int i = 2; i < 16; i++)
            point_pool[i] = $urandom_range(0, N_POINTS - 1);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // Directed: table extremes, unused code, both query orders
        write_reg(CFG_TREE_COUNT, 16'd2);
        write_reg(CFG_POINT_COUNT, 16'd4096);
        write_reg(CFG_MU_THRESHOLD, 16'hFFFF);
        load_leaf(0, 0, N_NODES - 1);
        load_leaf(0, N_POINTS - 1, 0);
        load_leaf(1, 0, 256);
        load_leaf(1, N_POINTS - 1, 256);
        load_mass(0, 0, 8191);
        load_mass(1, 256, 0);
        load_mass(0, N_NODES - 1, 4096);
        spare_request(1'b1);
        spare_request(1'b0);
        query_pair(0, N_POINTS - 1);
        query_pair(N_POINTS - 1, 0);
        query_pair(0, 0);
        query_pair(N_POINTS - 1, N_POINTS - 1);

        // Single point: score saturates
        wait_idle(8);
        write_reg(CFG_POINT_COUNT, 16'd1);
        write_reg(CFG_MU_THRESHOLD, 16'd0);
        query_pair(0, N_POINTS - 1);

        // Zero tree and point counts, stray upper data bits
        wait_idle(8);
        write_reg(CFG_TREE_COUNT, 16'hFF00);
        write_reg(CFG_POINT_COUNT, 16'hE000);
        write_reg(CFG_MU_THRESHOLD, 16'd1);
        query_pair(0, N_POINTS - 1);
        query_pair(0, 0);

        // Whole forest with near-full masses
        wait_idle(8);
        heavy_masses = 1'b1;
        write_reg(CFG_TREE_COUNT, 16'd128);
        write_reg(CFG_POINT_COUNT, 16'd4096);
        write_reg(CFG_MU_THRESHOLD, 16'd49152);
        query_pair(0, N_POINTS - 1);
        query_pair(N_POINTS - 1, 0);
        heavy_masses = 1'b0;
        wait_idle(8);
        write_reg(CFG_POINT_COUNT, 16'd8191);
        query_pair(0, N_POINTS - 1);
        wait_idle(8);
        write_reg(CFG_TREE_COUNT, 16'd255);
        write_reg(CFG_POINT_COUNT, 16'd4096);
        write_reg(CFG_MU_THRESHOLD, 16'd0);
        query_pair(N_POINTS - 1, 0);

        // Random phases, each with its own configuration
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle(8);
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TREE_COUNT, {8'($urandom), 8'd0});
                1:       write_reg(CFG_TREE_COUNT, 16'd1);
                default: write_reg(CFG_TREE_COUNT, 16'($urandom_range(2, 6)));
            endcase
            if (phase == 3)
                write_reg(CFG_TREE_COUNT, 16'($urandom_range(129, 255)));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_POINT_COUNT, 16'd1);
                1:       write_reg(CFG_POINT_COUNT, 16'd8191);
                2:       write_reg(CFG_POINT_COUNT, {3'($urandom), 13'd0});
                3:       write_reg(CFG_POINT_COUNT, 16'd4096);
                default: write_reg(CFG_POINT_COUNT, 16'($urandom_range(1, 8191)));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_MU_THRESHOLD, 16'd0);
                1:       write_reg(CFG_MU_THRESHOLD, 16'hFFFF);
                default: write_reg(CFG_MU_THRESHOLD, 16'($urandom));
            endcase
            stop_at = sent_count + 40;
            while (sent_count < stop_at)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    query_pair(pick_point(), pick_point());
                else if (pick < 65)
                    load_leaf($urandom_range(0, N_TREES - 1), pick_point(), random_node());
                else if (pick < 80)
                    load_mass($urandom_range(0, N_TREES - 1), random_node(), random_mass());
                else if (pick < 85)
                    spare_request(1'b0);
                else
                begin
                    pick = pick_point();
                    query_pair(pick, pick);
                end
            end
        end

        // Drain, then give stray results time to show up
        wait_idle(50);
        if (mismatch_count == 0)
            $display("forest_mass_dissimilarity test passed");
        else
            $display("forest_mass_dissimilarity test failed");
        $finish;
    end

endmodule
